/* design/i2cms_pkg.sv */
// Package for the I2C master transaction sequencer.
// Holds item and result types, status codes and control bit masks.
// Depends on nothing; every other design file but i2cms_txbuf refers to it by scoped names.
package i2cms_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_EVENT = 2'd2;

	// Transfer modes held in the configuration register.
	localparam logic [1:0] MODE_TX    = 2'd0;
	localparam logic [1:0] MODE_RX    = 2'd1;
	localparam logic [1:0] MODE_TX_RX = 2'd2;

	// Bus controller status codes.
	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_RESTART  = 8'h10;
	localparam logic [7:0] ST_ADDR_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_ACK = 8'h28;
	localparam logic [7:0] ST_RX_FIRST = 8'h40;
	localparam logic [7:0] ST_RX_DATA  = 8'h50;
	localparam logic [7:0] ST_RX_LAST  = 8'h58;

	// Control register bits.
	localparam logic [6:0] CTL_NONE = 7'h00;
	localparam logic [6:0] CTL_EN   = 7'h40;
	localparam logic [6:0] CTL_STA  = 7'h20;
	localparam logic [6:0] CTL_STO  = 7'h10;
	localparam logic [6:0] CTL_SI   = 7'h08;
	localparam logic [6:0] CTL_AA   = 7'h04;

	// Read/write bit appended to the slave address.
	localparam logic RW_WRITE = 1'b0;
	localparam logic RW_READ  = 1'b1;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_MODE = 1'd1;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] byte_value;
		logic [7:0] status_code;
		logic [4:0] tx_length;
		logic [7:0] rx_length;
	} item_t;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] write_byte;
		logic [6:0] control_set;
		logic [6:0] control_clear;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       done_res;
	} result_t;

endpackage

/* design/i2cms_ifs.sv */
// Valid/ready channel interfaces of the I2C master transaction sequencer.
// Depends on i2cms_pkg for the item and result types.

interface i2cms_item_if;
	logic                valid;
	logic                ready;
	i2cms_pkg::item_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cms_result_if;
	logic                valid;
	logic                ready;
	i2cms_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/i2c_master_transaction_sequencer.sv */
// Top level of the I2C master transaction sequencer.
// Depends on i2cms_pkg, the channel interfaces, i2cms_txbuf and i2cms_decode.
//
// Usage: items arrive on the valid/ready channel "items" and carry either a
// transmit byte to buffer, a transaction start with byte counts, or a bus
// status event. Each start and each known status event yields one transaction
// on the "results" channel with the data register write, the control bits to
// set and clear, any received byte and the completion flag. Load items,
// unknown status codes and the unused item kind yield nothing.
// Configuration (slave address, transfer mode) is written on cfg_we with
// cfg_index and cfg_data while the block is idle; the user is bound to this, the block does not enforce it.
// Timing: an accepted item is held in the input register, where the
// transmit buffer read completes, and its result then goes into the output register.
// One item is accepted per cycle while results are taken; the input register
// and the output register are the two stages that set this rate.
// When the receiver stalls, the output register holds its transaction, one
// more item waits in the input register, and then items stops accepting.
// Reset (arst_n low) empties both registers and clears the counts, pointers,
// completion flag and configuration; buffer contents are not cleared.
module i2c_master_transaction_sequencer #(
	parameter int TX_DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [i2cms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [i2cms_pkg::CFG_DATA_W-1:0]       cfg_data,
	i2cms_item_if.sink                             items,
	i2cms_result_if.source                         results
);

	localparam int PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int REM_W = $clog2(TX_DEPTH + 1);

	// Configuration registers.
	logic [6:0] slave_addr_q;
	logic [1:0] xfer_mode_q;

	// Sequencer state.
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [REM_W-1:0] tx_rem_q;
	logic [7:0]       rx_rem_q;
	logic             finished_q;

	// Input stage and output register.
	logic               valid_s1;
	i2cms_pkg::item_t   item_s1;
	logic               res_valid_q;
	i2cms_pkg::result_t res_q;

	// Decode outputs.
	logic               has_result;
	i2cms_pkg::result_t result;
	logic               tx_push;
	logic               tx_pop;
	logic [REM_W-1:0]   tx_rem_nxt;
	logic [7:0]         rx_rem_nxt;
	logic               finished_nxt;
	logic [7:0]         tx_byte_s1;

	logic             fire_s1;
	logic             accept;
	logic [PTR_W-1:0] rd_ptr_nxt;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] wr_ptr_inc;
	logic [PTR_W-1:0] rd_ptr_inc;

	// Pointers wrap at the buffer depth.
	assign wr_ptr_inc = (wr_ptr_q == PTR_W'(TX_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_ptr_inc = (rd_ptr_q == PTR_W'(TX_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);

	// Handshake: the input stage advances unless its result would overwrite
	// a transaction still waiting in the output register.
	assign fire_s1      = valid_s1 && (!has_result || !res_valid_q || results.ready);
	assign items.ready  = !valid_s1 || fire_s1;
	assign accept       = items.valid && items.ready;
	assign rd_ptr_nxt   = tx_pop ? rd_ptr_inc : rd_ptr_q;
	assign rd_addr      = fire_s1 ? rd_ptr_nxt : rd_ptr_q;

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	// Transmit buffer: the read for the next item is issued as it is accepted.
	i2cms_txbuf #(
		.DEPTH  (TX_DEPTH),
		.ADDR_W (PTR_W)
	) u_txbuf (
		.clk   (clk),
		.we    (fire_s1 && tx_push),
		.waddr (wr_ptr_q),
		.wdata (item_s1.byte_value),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (tx_byte_s1)
	);

	i2cms_decode #(
		.TX_DEPTH (TX_DEPTH),
		.REM_W    (REM_W)
	) u_decode (
		.item         (item_s1),
		.tx_byte      (tx_byte_s1),
		.tx_rem       (tx_rem_q),
		.rx_rem       (rx_rem_q),
		.finished     (finished_q),
		.slave_addr   (slave_addr_q),
		.xfer_mode    (xfer_mode_q),
		.has_result   (has_result),
		.result       (result),
		.tx_push      (tx_push),
		.tx_pop       (tx_pop),
		.tx_rem_nxt   (tx_rem_nxt),
		.rx_rem_nxt   (rx_rem_nxt),
		.finished_nxt (finished_nxt)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 7'd0;
			xfer_mode_q  <= i2cms_pkg::MODE_TX;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cms_pkg::CFG_SLAVE_ADDR:    slave_addr_q <= cfg_data;
				i2cms_pkg::CFG_TRANSFER_MODE: xfer_mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= items.data;
		end
	end

	// Sequencer state update as an item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			tx_rem_q   <= '0;
			rx_rem_q   <= 8'd0;
			finished_q <= 1'b0;
		end else if (fire_s1) begin
			if (tx_push) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			rd_ptr_q   <= rd_ptr_nxt;
			tx_rem_q   <= tx_rem_nxt;
			rx_rem_q   <= rx_rem_nxt;
			finished_q <= finished_nxt;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && has_result) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire_s1 && has_result) begin
			res_q <= result;
		end
	end

endmodule

/* design/i2cms_txbuf.sv */
// Transmit byte buffer: one write port and one registered read port.
// A write and a read of the same entry in one cycle returns the new byte.
// Depends on nothing outside this file.
module i2cms_txbuf #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read with forwarding of a same-cycle write.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/i2cms_decode.sv */
// Decode of one item against the sequencer state: result and next state.
// Purely combinational; depends on i2cms_pkg.
module i2cms_decode #(
	parameter int TX_DEPTH = 16,
	parameter int REM_W    = 5
) (
	input  i2cms_pkg::item_t   item,
	input  logic [7:0]         tx_byte,
	input  logic [REM_W-1:0]   tx_rem,
	input  logic [7:0]         rx_rem,
	input  logic               finished,
	input  logic [6:0]         slave_addr,
	input  logic [1:0]         xfer_mode,
	output logic               has_result,
	output i2cms_pkg::result_t result,
	output logic               tx_push,
	output logic               tx_pop,
	output logic [REM_W-1:0]   tx_rem_nxt,
	output logic [7:0]         rx_rem_nxt,
	output logic               finished_nxt
);

	localparam int CMP_W = (REM_W > 5) ? REM_W : 5;

	logic [CMP_W-1:0] txl_ext;
	logic [7:0]       rx_dec;
	logic             tx_empty;

	assign txl_ext  = CMP_W'(item.tx_length);
	assign tx_empty = (tx_rem == '0);
	assign rx_dec   = (rx_rem != 8'd0) ? (rx_rem - 8'd1) : rx_rem;

	always_comb begin
		has_result           = 1'b0;
		result.write_valid   = 1'b0;
		result.write_byte    = 8'd0;
		result.control_set   = i2cms_pkg::CTL_NONE;
		result.control_clear = i2cms_pkg::CTL_NONE;
		result.rx_valid      = 1'b0;
		result.rx_byte       = 8'd0;
		tx_push              = 1'b0;
		tx_pop               = 1'b0;
		tx_rem_nxt           = tx_rem;
		rx_rem_nxt           = rx_rem;
		finished_nxt         = finished;

		case (item.mode)
			i2cms_pkg::KIND_LOAD: begin
				tx_push = 1'b1;
			end
			i2cms_pkg::KIND_START: begin
				// Arm a transaction; transmit count saturates at the buffer depth.
				has_result         = 1'b1;
				result.control_set = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_STA;
				if (txl_ext > CMP_W'(TX_DEPTH)) begin
					tx_rem_nxt = REM_W'(TX_DEPTH);
				end else begin
					tx_rem_nxt = REM_W'(txl_ext);
				end
				rx_rem_nxt   = item.rx_length;
				finished_nxt = 1'b0;
			end
			i2cms_pkg::KIND_EVENT: begin
				has_result = 1'b1;
				case (item.status_code)
					i2cms_pkg::ST_START: begin
						result.write_valid = 1'b1;
						if ((xfer_mode == i2cms_pkg::MODE_TX)
								|| (xfer_mode == i2cms_pkg::MODE_TX_RX)) begin
							result.write_byte = {slave_addr, i2cms_pkg::RW_WRITE};
						end else begin
							result.write_byte = {slave_addr, i2cms_pkg::RW_READ};
						end
						result.control_clear = i2cms_pkg::CTL_STA | i2cms_pkg::CTL_SI;
						finished_nxt = 1'b0;
					end
					i2cms_pkg::ST_RESTART: begin
						result.write_valid   = 1'b1;
						result.write_byte    = {slave_addr, i2cms_pkg::RW_READ};
						result.control_clear = i2cms_pkg::CTL_STA | i2cms_pkg::CTL_SI;
					end
					i2cms_pkg::ST_ADDR_ACK: begin
						if (tx_empty) begin
							result.control_set = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_STO;
							finished_nxt = 1'b1;
						end else begin
							result.write_valid = 1'b1;
							result.write_byte  = tx_byte;
							tx_pop     = 1'b1;
							tx_rem_nxt = tx_rem - REM_W'(1);
						end
						result.control_clear = i2cms_pkg::CTL_SI;
					end
					i2cms_pkg::ST_DATA_ACK: begin
						if (!tx_empty) begin
							result.write_valid = 1'b1;
							result.write_byte  = tx_byte;
							tx_pop     = 1'b1;
							tx_rem_nxt = tx_rem - REM_W'(1);
						end else if (xfer_mode == i2cms_pkg::MODE_TX) begin
							result.control_set = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_STO;
							finished_nxt = 1'b1;
						end else if (xfer_mode == i2cms_pkg::MODE_TX_RX) begin
							result.control_set = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_STA;
						end
						result.control_clear = i2cms_pkg::CTL_SI;
					end
					i2cms_pkg::ST_RX_FIRST: begin
						// Acknowledge unless only one byte is expected.
						if (rx_rem == 8'd1) begin
							result.control_set = i2cms_pkg::CTL_EN;
						end else begin
							result.control_set = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_AA;
						end
						result.control_clear = i2cms_pkg::CTL_SI;
					end
					i2cms_pkg::ST_RX_DATA: begin
						result.rx_valid = 1'b1;
						result.rx_byte  = item.byte_value;
						rx_rem_nxt      = rx_dec;
						if (rx_dec == 8'd1) begin
							result.control_set   = i2cms_pkg::CTL_EN;
							result.control_clear = i2cms_pkg::CTL_SI | i2cms_pkg::CTL_AA;
						end else begin
							result.control_set   = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_AA;
							result.control_clear = i2cms_pkg::CTL_SI;
						end
					end
					i2cms_pkg::ST_RX_LAST: begin
						result.rx_valid      = 1'b1;
						result.rx_byte       = item.byte_value;
						result.control_set   = i2cms_pkg::CTL_EN | i2cms_pkg::CTL_STO;
						result.control_clear = i2cms_pkg::CTL_SI;
						finished_nxt         = 1'b1;
					end
					default: begin
						// Unknown status code: no result, no state change.
						has_result = 1'b0;
					end
				endcase
			end
			default: begin
				// Unused item kind is dropped.
				has_result = 1'b0;
			end
		endcase

		result.done_res = finished_nxt;
	end

endmodule
